/* hdl/mpq_pkg.sv */
// Package for the unsorted-array max priority queue.
// Holds store sizing, entry and result types, codes and the sequencer states.
// No dependencies.
package mpq_pkg;

    localparam int DEPTH       = 128;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int PRIO_W      = 16;
    localparam int PAYLOAD_W   = 32;
    localparam int STATUS_W    = 2;
    localparam int ENTRY_CNT_W = 8;

    typedef enum logic {
        FN_INSERT = 1'b0,
        FN_REMOVE = 1'b1
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT
    } t_state;

    typedef struct packed {
        logic [PRIO_W-1:0]    prio;
        logic [PAYLOAD_W-1:0] payload;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] raddr;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_entry            wdata;
    } t_ram_req;

    typedef struct packed {
        logic              dat_vld;
        logic              first;
        logic [ADDR_W-1:0] idx;
    } t_scan_ctl;

    typedef struct packed {
        t_entry                 entry;
        t_status                status;
        logic [ENTRY_CNT_W-1:0] entry_count;
    } t_result;

endpackage

/* hdl/mpq_in_if.sv */
// Input channel of the priority queue: one operation word per handshake.
// Depends on mpq_pkg for field widths.
interface mpq_in_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [mpq_pkg::PRIO_W-1:0]    item_priority;
    logic [mpq_pkg::PAYLOAD_W-1:0] item_payload;

    modport source (output valid, output func, output item_priority, output item_payload,
                    input ready);
    modport sink   (input valid, input func, input item_priority, input item_payload,
                    output ready);
endinterface

/* hdl/mpq_out_if.sv */
// Output channel of the priority queue: one result word per handshake.
// Depends on mpq_pkg for field widths.
interface mpq_out_if;
    logic                            valid;
    logic                            ready;
    logic [mpq_pkg::PRIO_W-1:0]      out_priority;
    logic [mpq_pkg::PAYLOAD_W-1:0]   out_payload;
    logic [mpq_pkg::STATUS_W-1:0]    status;
    logic [mpq_pkg::ENTRY_CNT_W-1:0] entry_count;

    modport source (output valid, output out_priority, output out_payload, output status,
                    output entry_count, input ready);
    modport sink   (input valid, input out_priority, input out_payload, input status,
                    input entry_count, output ready);
endinterface

/* hdl/mpq_ram.sv */
// Generic simple dual-port RAM: one write and one registered read per cycle.
// Standalone; read-before-write on the same address.
module mpq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* hdl/mpq_scan.sv */
// Running maximum over the entries read back during a remove scan.
// Depends on mpq_pkg; fed by mpq_ctrl and the store read port.
module mpq_scan (
    input  logic                           i_clk,
    input  mpq_pkg::t_scan_ctl             i_ctl,
    input  mpq_pkg::t_entry                i_rd_data,
    output logic [mpq_pkg::ADDR_W-1:0]     o_best_idx,
    output mpq_pkg::t_entry                o_best
);
    import mpq_pkg::*;

    logic [ADDR_W-1:0] r_best_idx;
    t_entry            r_best;
    logic [ADDR_W-1:0] n_best_idx;
    t_entry            n_best;
    logic              take;

    // strict greater keeps the lowest index on ties
    always_comb begin
        take       = i_ctl.first || (i_rd_data.prio > r_best.prio);
        n_best_idx = take ? i_ctl.idx : r_best_idx;
        n_best     = take ? i_rd_data : r_best;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.dat_vld) begin
            r_best_idx <= n_best_idx;
            r_best     <= n_best;
        end
    end

    assign o_best_idx = n_best_idx;
    assign o_best     = n_best;
endmodule

/* hdl/mpq_ctrl.sv */
// Sequencer of the priority queue: fill count, insert writes, remove scan and
// hole fill-in write-back. Depends on mpq_pkg, mpq_in_if and mpq_scan.
module mpq_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    mpq_in_if.sink                     i_in,
    input  mpq_pkg::t_entry            i_rd_data,
    output mpq_pkg::t_ram_req          o_ram,
    input  logic                       i_take,
    output logic                       o_res_vld,
    output mpq_pkg::t_result           o_res
);
    import mpq_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count;
    logic [ADDR_W-1:0] r_ptr;
    logic              r_issue_done;
    logic              r_dvld;
    logic [ADDR_W-1:0] r_didx;
    t_entry            r_res;
    t_status           r_status;

    logic              accept;
    logic              is_remove;
    logic              full;
    logic              empty;
    logic [ADDR_W-1:0] last_idx;
    logic              scan_last;
    t_scan_ctl         scan_ctl;
    logic [ADDR_W-1:0] best_idx;
    t_entry            best;

    assign accept    = i_in.valid && i_in.ready;
    assign is_remove = (i_in.func == FN_REMOVE);
    assign full      = (r_count == CNT_W'(DEPTH));
    assign empty     = (r_count == '0);
    assign last_idx  = ADDR_W'(r_count - 1'b1);
    assign scan_last = r_dvld && (r_didx == last_idx);

    always_comb begin
        scan_ctl.dat_vld = r_dvld;
        scan_ctl.first   = (r_didx == '0);
        scan_ctl.idx     = r_didx;
    end

    mpq_scan u_scan (
        .i_clk      (i_clk),
        .i_ctl      (scan_ctl),
        .i_rd_data  (i_rd_data),
        .o_best_idx (best_idx),
        .o_best     (best)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (is_remove && !empty) ? S_SCAN : S_WAIT;
                end
            end
            S_SCAN: begin
                if (scan_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready        = (r_state == S_IDLE);
        o_res_vld         = (r_state == S_WAIT);
        o_res.entry       = r_res;
        o_res.status      = r_status;
        o_res.entry_count = ENTRY_CNT_W'(r_count);
        o_ram.re          = (r_state == S_SCAN) && !r_issue_done;
        o_ram.raddr       = r_ptr;
        o_ram.we          = 1'b0;
        o_ram.waddr       = ADDR_W'(r_count);
        o_ram.wdata.prio    = i_in.item_priority;
        o_ram.wdata.payload = i_in.item_payload;
        if (accept && !is_remove && !full) begin
            o_ram.we = 1'b1;
        end else if ((r_state == S_SCAN) && scan_last) begin
            // move the last entry into the hole
            o_ram.we    = 1'b1;
            o_ram.waddr = best_idx;
            o_ram.wdata = i_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_issue_done <= 1'b1;
            r_dvld       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dvld  <= o_ram.re;
            if (accept) begin
                r_ptr        <= '0;
                r_issue_done <= 1'b0;
                if (!is_remove && !full) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (o_ram.re) begin
                r_ptr <= r_ptr + 1'b1;
                if (r_ptr == last_idx) begin
                    r_issue_done <= 1'b1;
                end
            end
            if ((r_state == S_SCAN) && scan_last) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_didx <= r_ptr;
        if (accept) begin
            r_res <= '0;
            if (is_remove) begin
                r_status <= empty ? ST_EMPTY : ST_OK;
            end else begin
                r_status <= full ? ST_FULL : ST_OK;
            end
        end
        if ((r_state == S_SCAN) && scan_last) begin
            r_res <= best;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    a_wb_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && o_ram.we) |-> (o_ram.waddr <= last_idx))
        else $error("write-back outside stored entries");

    a_empty_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_remove && empty) |=> ((r_state == S_WAIT) && (r_status == ST_EMPTY)))
        else $error("remove on empty store not reported");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !is_remove && !full) |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow the count");

    a_scan_no_read_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_last |-> !o_ram.re)
        else $error("read issued past the last entry");
endmodule

/* hdl/max_priority_queue_unsorted_top.sv */
// Top level of the unsorted-array max priority queue.
// Depends on mpq_pkg, mpq_in_if, mpq_out_if, mpq_ram and mpq_ctrl.
//
// Usage:
//   i_in carries one operation word: func (insert or remove), item_priority and
//   item_payload. o_out returns exactly one result word per operation:
//   removed priority and payload (zero unless a remove succeeded), a status
//   (ok, insert rejected when full, remove on empty) and the entry count after
//   the operation.
//   Entries live in one 48-bit synchronous RAM of 128 words. An insert writes
//   the word at the fill count; its result is valid in the cycle after
//   acceptance, and no next word is taken before that result has been handed to the output register.
//   A remove on n stored entries reads them one per cycle through the single
//   RAM read port, keeps the first highest priority, then writes the last
//   entry into the hole; the result follows that write-back, and no next word
//   is taken before it has been handed to the output register. A remove on an
//   empty store skips the scan and reports its status.
//   Reset clears the fill count and the control state; the RAM is not cleared,
//   since only entries below the count are ever read.
//   A result sits in the output register until taken; while the receiver
//   stalls, one finished operation more may wait inside and no further
//   operation is taken.
module max_priority_queue_unsorted_top (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mpq_in_if.sink   i_in,
    mpq_out_if.source o_out
);
    import mpq_pkg::*;

    t_ram_req ram_req;
    t_entry   rd_data;
    logic     res_vld;
    t_result  res;
    logic     take;

    logic     r_out_valid;
    t_result  r_out;

    mpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (rd_data)
    );

    mpq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_rd_data (rd_data),
        .o_ram     (ram_req),
        .i_take    (take),
        .o_res_vld (res_vld),
        .o_res     (res)
    );

    // load the output register whenever it is free or being drained
    assign take = res_vld && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.out_priority = r_out.entry.prio;
    assign o_out.out_payload  = r_out.entry.payload;
    assign o_out.status       = r_out.status;
    assign o_out.entry_count  = r_out.entry_count;
endmodule
